/* sv/bpt_pkg.sv */
// Shared types and constants for the barometer temperature compensation block.
package bpt_pkg;

  // Configuration port index width and data width.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Number of register stages in the compensation pipeline.
  localparam int unsigned NumStages = 9;

  // Reference temperature and saturation limits.
  localparam int TempRefCenti = 2000;
  localparam int TempMin      = -4000;
  localparam int TempMax      = 8500;
  localparam int PresMin      = 1000;
  localparam int PresMax      = 120000;

  // Calibration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENS        = 3'd0,
    CFG_OFFSET      = 3'd1,
    CFG_SENS_TEMP   = 3'd2,
    CFG_OFFSET_TEMP = 3'd3,
    CFG_REF_TEMP    = 3'd4,
    CFG_TEMP_SLOPE  = 3'd5
  } cfg_idx_e;

  // The six factory calibration words.
  typedef struct packed {
    logic [CfgDataW-1:0] sens;
    logic [CfgDataW-1:0] offset;
    logic [CfgDataW-1:0] sens_temp;
    logic [CfgDataW-1:0] offset_temp;
    logic [CfgDataW-1:0] ref_temp;
    logic [CfgDataW-1:0] temp_slope;
  } cfg_t;

endpackage

/* sv/bpt_cfg_regs.sv */
// Calibration register file written through the configuration port.
module bpt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [bpt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bpt_pkg::CfgDataW-1:0]  cfg_data_i,
  output bpt_pkg::cfg_t                 cfg_o
);

  bpt_pkg::cfg_t cfg_q;
  bpt_pkg::cfg_t cfg_d;

  // Decode the index; writes to unused indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpt_pkg::CFG_SENS:        cfg_d.sens        = cfg_data_i;
        bpt_pkg::CFG_OFFSET:      cfg_d.offset      = cfg_data_i;
        bpt_pkg::CFG_SENS_TEMP:   cfg_d.sens_temp   = cfg_data_i;
        bpt_pkg::CFG_OFFSET_TEMP: cfg_d.offset_temp = cfg_data_i;
        bpt_pkg::CFG_REF_TEMP:    cfg_d.ref_temp    = cfg_data_i;
        bpt_pkg::CFG_TEMP_SLOPE:  cfg_d.temp_slope  = cfg_data_i;
        default:                  cfg_d             = cfg_q;
      endcase
    end
  end

  // Register storage, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // A write to the sensitivity word lands in the register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == bpt_pkg::CFG_SENS) |=> cfg_q.sens == $past(cfg_data_i))
    else $error("sensitivity word not updated by write");

  // An index beyond the register list leaves every register untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i > bpt_pkg::CFG_TEMP_SLOPE) |=> $stable(cfg_q))
    else $error("write to unused index changed a register");

  // Without a write the registers hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(cfg_q))
    else $error("calibration registers changed without a write");

endmodule

/* sv/baro_pressure_temp_compensation.sv */
// Top level: pipelined second-order barometer temperature and pressure compensation.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------------------------
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in_valid_i  / in_ready_o  | raw_pressure_i, raw_temperature_i
//  out     | out_valid_o / out_ready_i | temperature_centi_o, pressure_pa_o
//
// One transaction is accepted per cycle unless a stalled output has backed the pipeline up
// to stage 0; each result passes through the stage registers up to the stage 8 output register.
// The depth is set by the chain of calibration multiplies and the split 24 x 38 bit
// pressure product, each followed by a register.
// Reset clears the calibration registers and all stage valid bits; no clearing pass.
// Each stage holds when the one after it is full and stalled, so bubbles are squeezed out
// and a transaction is taken while a finished result still waits at the output.
module baro_pressure_temp_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bpt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [23:0]                   raw_pressure_i,
  input  logic [23:0]                   raw_temperature_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [14:0]            temperature_centi_o,
  output logic [16:0]                   pressure_pa_o
);

  localparam int unsigned NS = bpt_pkg::NumStages;

  bpt_pkg::cfg_t cfg;

  // Calibration registers.
  bpt_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // Stage valid bits and per-stage load enables.
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = out_ready_i || !vld_q[NS-1];
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];

  // Stage 0: temperature difference against the reference.
  logic signed [24:0] dt_d, dt_q;
  logic [23:0]        pr0_q;

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cfg.ref_temp, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dt_q  <= dt_d;
      pr0_q <= raw_pressure_i;
    end
  end

  // Stage 1: four independent products of the temperature difference.
  logic signed [41:0] mt_d, mo_d, ms_d, mt_q, mo_q, ms_q;
  logic signed [49:0] mdd_d, mdd_q;
  logic [23:0]        pr1_q;

  assign mt_d  = dt_q * $signed({1'b0, cfg.temp_slope});
  assign mo_d  = dt_q * $signed({1'b0, cfg.offset_temp});
  assign ms_d  = dt_q * $signed({1'b0, cfg.sens_temp});
  assign mdd_d = dt_q * dt_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mt_q  <= mt_d;
      mo_q  <= mo_d;
      ms_q  <= ms_d;
      mdd_q <= mdd_d;
      pr1_q <= pr0_q;
    end
  end

  // Stage 2: first-order temperature, offset and sensitivity.
  logic signed [18:0] tsh;
  logic signed [34:0] mo_sh;
  logic signed [33:0] ms_sh;
  logic signed [19:0] temp1_d, temp1_q;
  logic signed [18:0] dlt_q;
  logic [17:0]        ddsh_q;
  logic               low2_q;
  logic signed [37:0] off1_d, sens1_d, off1_q, sens1_q;
  logic [23:0]        pr2_q;

  assign tsh     = mt_q[41:23];
  assign mo_sh   = mo_q[41:7];
  assign ms_sh   = ms_q[41:8];
  assign temp1_d = 20'(bpt_pkg::TempRefCenti) + 20'(tsh);
  assign off1_d  = $signed({6'b0, cfg.offset, 16'h0000}) + 38'(mo_sh);
  assign sens1_d = $signed({7'b0, cfg.sens, 15'h0000}) + 38'(ms_sh);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      temp1_q <= temp1_d;
      dlt_q   <= tsh;
      low2_q  <= tsh[18];
      ddsh_q  <= mdd_q[48:31];
      off1_q  <= off1_d;
      sens1_q <= sens1_d;
      pr2_q   <= pr1_q;
    end
  end

  // Stage 3: square of the distance below the reference; corrected temperature.
  logic signed [37:0] sq_full;
  logic [34:0]        sq_q;
  logic signed [20:0] temp2_d, temp2_q;
  logic signed [37:0] off1b_q, sens1b_q;
  logic               low3_q;
  logic [23:0]        pr3_q;

  assign sq_full = dlt_q * dlt_q;
  assign temp2_d = low2_q ? 21'(temp1_q) - $signed({3'b000, ddsh_q}) : 21'(temp1_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sq_q     <= sq_full[34:0];
      temp2_q  <= temp2_d;
      off1b_q  <= off1_q;
      sens1b_q <= sens1_q;
      low3_q   <= low2_q;
      pr3_q    <= pr2_q;
    end
  end

  // Stage 4: second-order corrections of offset and sensitivity.
  logic [37:0]        sq5;
  logic [37:0]        off_cor, sens_cor;
  logic signed [37:0] off2_d, sens2_d, off2_q, sens2_q;
  logic signed [20:0] temp4_q;
  logic [23:0]        pr4_q;

  assign sq5      = {1'b0, sq_q, 2'b00} + {3'b000, sq_q};
  assign off_cor  = low3_q ? {1'b0, sq5[37:1]} : '0;
  assign sens_cor = low3_q ? {2'b00, sq5[37:2]} : '0;
  assign off2_d   = off1b_q - $signed(off_cor);
  assign sens2_d  = sens1b_q - $signed(sens_cor);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      off2_q  <= off2_d;
      sens2_q <= sens2_d;
      temp4_q <= temp2_q;
      pr4_q   <= pr3_q;
    end
  end

  // Stage 5: pressure times sensitivity as two partial products.
  logic [42:0]        plo_d, plo_q;
  logic signed [43:0] phi_d, phi_q;
  logic signed [37:0] off5_q;
  logic signed [20:0] temp5_q;

  assign plo_d = pr4_q * sens2_q[18:0];
  assign phi_d = $signed({1'b0, pr4_q}) * $signed(sens2_q[37:19]);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      off5_q  <= off2_q;
      temp5_q <= temp4_q;
    end
  end

  // Stage 6: combine the partial products.
  logic signed [63:0] prod_d, prod_q;
  logic signed [37:0] off6_q;
  logic signed [20:0] temp6_q;

  assign prod_d = (64'(phi_q) <<< 19) + $signed({21'b0, plo_q});

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      prod_q  <= prod_d;
      off6_q  <= off5_q;
      temp6_q <= temp5_q;
    end
  end

  // Stage 7: subtract the offset and scale; saturate the temperature.
  logic signed [42:0] prod_sh;
  logic signed [43:0] pdiff;
  logic signed [28:0] praw_q;
  logic signed [14:0] tsat_d, tsat_q;

  assign prod_sh = prod_q[63:21];
  assign pdiff   = 44'(prod_sh) - 44'(off6_q);

  always_comb begin
    if (temp6_q < bpt_pkg::TempMin) begin
      tsat_d = 15'(bpt_pkg::TempMin);
    end else if (temp6_q > bpt_pkg::TempMax) begin
      tsat_d = 15'(bpt_pkg::TempMax);
    end else begin
      tsat_d = temp6_q[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      praw_q <= pdiff[43:15];
      tsat_q <= tsat_d;
    end
  end

  // Stage 8: saturate the pressure into the output register.
  logic [16:0]        psat_d, pout_q;
  logic signed [14:0] tout_q;

  always_comb begin
    if (praw_q < bpt_pkg::PresMin) begin
      psat_d = 17'(bpt_pkg::PresMin);
    end else if (praw_q > bpt_pkg::PresMax) begin
      psat_d = 17'(bpt_pkg::PresMax);
    end else begin
      psat_d = praw_q[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      pout_q <= psat_d;
      tout_q <= tsat_q;
    end
  end

  assign temperature_centi_o = tout_q;
  assign pressure_pa_o       = pout_q;

  // Results leave saturated to the rated temperature range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temperature_centi_o >= 15'(bpt_pkg::TempMin)) &&
                    (temperature_centi_o <= 15'(bpt_pkg::TempMax)))
    else $error("temperature result outside the rated range");

  // Results leave saturated to the rated pressure range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pressure_pa_o >= 17'(bpt_pkg::PresMin)) &&
                    (pressure_pa_o <= 17'(bpt_pkg::PresMax)))
    else $error("pressure result outside the rated range");

  // A full pipeline facing a stalled output takes nothing in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the pipeline is full and stalled");

  // An accepted transaction occupies the first stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule
